// ===== src/bb3_pkg.sv =====
`default_nettype none
package bb3_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   // Pixel window: two rows plus a few pixels, kept as one circular store.
   localparam int WIN_SIZE   = 2 * MAX_WIDTH + 4;

   localparam int PTR_W = $clog2(WIN_SIZE);
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WID_W = 11;
   localparam int HGT_W = 13;
   localparam int CSR_W = 13;
   localparam int SUM_W = 12;
   localparam int NUM_W = 13;
   localparam int DEN_W = 5;

   localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(1024);
   localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(768);

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic       accept;
      logic       store;
      logic       acc_clr;
      logic       rd_en;
      logic [1:0] srow;
      logic [1:0] scol;
      logic       div_init;
      logic       div_step;
      logic [2:0] step;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic pixel_ok;
      logic drain_idle;
      logic emit_ok;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== src/bb3_if.sv =====
`default_nettype none
interface bb3_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       frame_end;
   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface
`default_nettype wire

// ===== src/bb3_ctrl.sv =====
`default_nettype none
module bb3_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bb3_pkg::sts_type sts,
   output bb3_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      IDLE, STORE, CHECK, GATHER, GLAST, DIV_LOAD, DIVIDE, EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] srow_ff, srow_in;
   logic [1:0] scol_ff, scol_in;
   logic [2:0] step_ff, step_in;

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      state_in = state_ff;
      srow_in  = srow_ff;
      scol_in  = scol_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.srow = srow_ff;
      cmd.scol = scol_ff;
      cmd.step = step_ff;
      unique case (state_ff)
         IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) state_in = STORE;
         end
         STORE: begin
            cmd.store = sts.pixel_ok;
            state_in  = sts.drain_idle ? IDLE : CHECK;
         end
         CHECK: begin
            if (sts.emit_ok) begin
               cmd.acc_clr = 1'b1;
               srow_in     = 2'd0;
               scol_in     = 2'd0;
               state_in    = GATHER;
            end else begin
               state_in = IDLE;
            end
         end
         GATHER: begin
            cmd.rd_en = 1'b1;
            if (scol_ff == 2'd2) begin
               scol_in = 2'd0;
               srow_in = srow_ff + 2'd1;
               if (srow_ff == 2'd2) state_in = GLAST;
            end else begin
               scol_in = scol_ff + 2'd1;
            end
         end
         GLAST: state_in = DIV_LOAD;
         DIV_LOAD: begin
            cmd.div_init = 1'b1;
            step_in      = 3'd7;
            state_in     = DIVIDE;
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 3'd1;
            if (step_ff == 3'd0) state_in = EMIT;
         end
         EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         srow_ff  <= 2'd0;
         scol_ff  <= 2'd0;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         srow_ff  <= srow_in;
         scol_ff  <= scol_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/bb3_div.sv =====
`default_nettype none
module bb3_div (
   input  wire logic                      clock,
   input  wire logic                      init,
   input  wire logic                      step,
   input  wire logic [2:0]                bit_idx,
   input  wire logic [bb3_pkg::NUM_W-1:0] num [3],
   input  wire logic [bb3_pkg::DEN_W-1:0] den,
   output logic [7:0]                     quo [3]
);

   logic [bb3_pkg::NUM_W-1:0] rem_ff [3];
   logic [7:0]                quo_ff [3];
   logic [bb3_pkg::NUM_W-1:0] den_ff;
   logic [bb3_pkg::NUM_W-1:0] shifted;

   // The quotient is below 256, so eight shifted compare-subtract steps suffice.
   assign shifted = den_ff << bit_idx;

   always_ff @(posedge clock) begin
      if (init) begin
         den_ff <= bb3_pkg::NUM_W'(den);
         for (int i = 0; i < 3; i++) begin
            rem_ff[i] <= num[i];
            quo_ff[i] <= 8'd0;
         end
      end else if (step) begin
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[i] >= shifted) begin
               rem_ff[i]          <= rem_ff[i] - shifted;
               quo_ff[i][bit_idx] <= 1'b1;
            end
         end
      end
   end

   assign quo = quo_ff;

endmodule
`default_nettype wire

// ===== src/bb3_dp.sv =====
`default_nettype none
module bb3_dp (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_idx,
   input  wire logic [bb3_pkg::CSR_W-1:0] csr_data,
   input  wire logic                      req_kind,
   input  wire bb3_pkg::pixel_type        req_pix,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   output bb3_pkg::pixel_type             rsp_pix,
   output logic                           rsp_frame_end,
   input  wire bb3_pkg::cmd_type          cmd,
   output bb3_pkg::sts_type               sts
);

   localparam int WIN = bb3_pkg::WIN_SIZE;

   logic [bb3_pkg::WID_W-1:0] width_ff;
   logic [bb3_pkg::HGT_W-1:0] height_ff;
   logic [bb3_pkg::WID_W-1:0] w_eff;
   logic [bb3_pkg::HGT_W-1:0] h_eff;
   logic [23:0]               prod;
   logic [bb3_pkg::CNT_W-1:0] total_ff;

   logic [bb3_pkg::CNT_W-1:0] taken_ff, given_ff;
   logic [bb3_pkg::PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [bb3_pkg::ROW_W-1:0] row_ff;
   logic [bb3_pkg::COL_W-1:0] col_ff;

   logic                      kind_ff;
   bb3_pkg::pixel_type        pix_ff;
   bb3_pkg::pixel_type        win_mem_ff [WIN];
   bb3_pkg::pixel_type        rd_data_ff;
   logic                      vld_ff;

   logic [bb3_pkg::SUM_W-1:0] sum_ff [3];
   logic [3:0]                cnt_ff;
   logic [bb3_pkg::NUM_W-1:0] num [3];
   logic [bb3_pkg::DEN_W-1:0] den;
   logic [7:0]                quo [3];

   logic                      rsp_valid_ff;
   bb3_pkg::pixel_type        rsp_pix_ff;
   logic                      rsp_end_ff;

   logic                      restart, last, below_total, in_frame;
   logic [12:0]               row_off, col_off, addr_sum;
   logic [bb3_pkg::PTR_W-1:0] rd_addr;

   always_comb begin
      if (width_ff == '0) w_eff = bb3_pkg::WID_W'(1);
      else if (width_ff > bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH))
         w_eff = bb3_pkg::WID_W'(bb3_pkg::MAX_WIDTH);
      else w_eff = width_ff;
      if (height_ff == '0) h_eff = bb3_pkg::HGT_W'(1);
      else if (height_ff > bb3_pkg::HGT_W'(bb3_pkg::MAX_HEIGHT))
         h_eff = bb3_pkg::HGT_W'(bb3_pkg::MAX_HEIGHT);
      else h_eff = height_ff;
   end

   assign prod = {13'd0, w_eff} * {11'd0, h_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bb3_pkg::WIDTH_RESET;
         height_ff <= bb3_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_idx)
            bb3_pkg::REG_FRAME_WIDTH:  width_ff  <= csr_data[bb3_pkg::WID_W-1:0];
            bb3_pkg::REG_FRAME_HEIGHT: height_ff <= csr_data[bb3_pkg::HGT_W-1:0];
            default: ;
         endcase
      end
      total_ff <= prod[bb3_pkg::CNT_W-1:0];
   end

   assign below_total = (taken_ff < total_ff);
   assign last        = (given_ff + bb3_pkg::CNT_W'(1) == total_ff);
   assign restart     = csr_we || (cmd.emit && last);

   assign sts.pixel_ok   = !kind_ff && below_total;
   assign sts.drain_idle = kind_ff && below_total;
   assign sts.emit_ok    = (given_ff < total_ff) &&
                           ((taken_ff == total_ff) ||
                            ({1'b0, taken_ff} >= {1'b0, given_ff} + 24'(w_eff) + 24'd2));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

   // Frame position counters; they restart on a register write and after the last result.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         taken_ff  <= '0;
         given_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         if (cmd.store) begin
            taken_ff  <= taken_ff + bb3_pkg::CNT_W'(1);
            wr_ptr_ff <= (wr_ptr_ff == bb3_pkg::PTR_W'(WIN - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
         end
         if (cmd.emit) begin
            given_ff  <= given_ff + bb3_pkg::CNT_W'(1);
            rd_ptr_ff <= (rd_ptr_ff == bb3_pkg::PTR_W'(WIN - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
            if (col_ff == bb3_pkg::COL_W'(w_eff - 1'b1)) begin
               col_ff <= '0;
               row_ff <= row_ff + 1'b1;
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         pix_ff  <= req_pix;
      end
   end

   // Neighbor address: the result pixel's slot plus a row and a column offset, modulo the window.
   always_comb begin
      unique case (cmd.srow)
         2'd0:    row_off = 13'(WIN) - 13'(w_eff);
         2'd2:    row_off = 13'(w_eff);
         default: row_off = 13'd0;
      endcase
      unique case (cmd.scol)
         2'd0:    col_off = 13'(WIN - 1);
         2'd2:    col_off = 13'd1;
         default: col_off = 13'd0;
      endcase
      addr_sum = 13'(rd_ptr_ff) + row_off + col_off;
      if (addr_sum >= 13'(2 * WIN)) rd_addr = bb3_pkg::PTR_W'(addr_sum - 13'(2 * WIN));
      else if (addr_sum >= 13'(WIN)) rd_addr = bb3_pkg::PTR_W'(addr_sum - 13'(WIN));
      else rd_addr = addr_sum[bb3_pkg::PTR_W-1:0];
      in_frame = !(cmd.srow == 2'd0 && row_ff == '0) &&
                 !(cmd.srow == 2'd2 && row_ff == bb3_pkg::ROW_W'(h_eff - 1'b1)) &&
                 !(cmd.scol == 2'd0 && col_ff == '0) &&
                 !(cmd.scol == 2'd2 && col_ff == bb3_pkg::COL_W'(w_eff - 1'b1));
   end

   always_ff @(posedge clock) begin
      if (cmd.store) win_mem_ff[wr_ptr_ff] <= pix_ff;
      if (cmd.rd_en) rd_data_ff <= win_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= cmd.rd_en && in_frame;
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_clr) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         cnt_ff <= 4'd0;
      end else if (vld_ff) begin
         sum_ff[0] <= sum_ff[0] + bb3_pkg::SUM_W'(rd_data_ff.red);
         sum_ff[1] <= sum_ff[1] + bb3_pkg::SUM_W'(rd_data_ff.green);
         sum_ff[2] <= sum_ff[2] + bb3_pkg::SUM_W'(rd_data_ff.blue);
         cnt_ff    <= cnt_ff + 4'd1;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = {sum_ff[i], 1'b0} + bb3_pkg::NUM_W'(cnt_ff);
      end
      den = {cnt_ff, 1'b0};
   end

   bb3_div u_div (
      .clock   (clock),
      .init    (cmd.div_init),
      .step    (cmd.div_step),
      .bit_idx (cmd.step),
      .num     (num),
      .den     (den),
      .quo     (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_pix_ff.red   <= quo[0];
         rsp_pix_ff.green <= quo[1];
         rsp_pix_ff.blue  <= quo[2];
         rsp_end_ff       <= last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pix       = rsp_pix_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule
`default_nettype wire

// ===== src/box_blur_3x3_rgb_top.sv =====
`default_nettype none
// Channel  Dir  Payload                                   Handshake
// req_if   in   kind, red_in, green_in, blue_in           valid/ready
// rsp_if   out  red_out, green_out, blue_out, frame_end   valid/ready
// csr_*    in   csr_idx, csr_data                         csr_we, no wait
//
// A request that yields a result goes through the nine window reads, one at a time through the
// single read port of the pixel window memory, then through an eight-step divider.
// A request that yields no result goes back to IDLE from STORE or from CHECK.
// Reset is synchronous and needs no clearing pass; the result register lets the next
// request enter while a result waits for rsp_if.ready.
module box_blur_3x3_rgb_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bb3_req_if.sink                        req_if,
   bb3_rsp_if.source                      rsp_if,
   input  wire logic                      csr_we,
   input  wire logic                      csr_idx,
   input  wire logic [bb3_pkg::CSR_W-1:0] csr_data
);

   bb3_pkg::cmd_type   cmd;
   bb3_pkg::sts_type   sts;
   bb3_pkg::pixel_type req_pix;
   bb3_pkg::pixel_type rsp_pix;
   logic               req_ready;

   assign req_pix.red   = req_if.red_in;
   assign req_pix.green = req_if.green_in;
   assign req_pix.blue  = req_if.blue_in;
   assign req_if.ready  = req_ready;

   assign rsp_if.red_out   = rsp_pix.red;
   assign rsp_if.green_out = rsp_pix.green;
   assign rsp_if.blue_out  = rsp_pix.blue;

   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bb3_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_idx       (csr_idx),
      .csr_data      (csr_data),
      .req_kind      (req_if.kind),
      .req_pix       (req_pix),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_pix       (rsp_pix),
      .rsp_frame_end (rsp_if.frame_end),
      .cmd           (cmd),
      .sts           (sts)
   );

`ifndef SYNTHESIS
   a_store_only_in_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> sts.pixel_ok)
      else $error("pixel stored past the end of the frame");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.rsp_free)
      else $error("result loaded over one not yet taken");

   a_one_request_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_ready) |=> !req_ready)
      else $error("request taken while the previous one is in progress");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/box_blur_3x3_rgb_top_tb.sv =====
module box_blur_3x3_rgb_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;
   localparam int   SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } blur_res_type;

   typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL} row_op_type;
   typedef enum logic [1:0] {CHK_PREDICT, CHK_TYPED, CHK_NONE} row_chk_type;

   typedef struct packed {
      row_op_type                 op;
      logic                      idx;
      logic [bb3_pkg::CSR_W-1:0] data;
      logic                      kind;
      bb3_pkg::pixel_type        px;
      row_chk_type               chk;
      blur_res_type              res;
   } dir_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_idx;
   logic [bb3_pkg::CSR_W-1:0] csr_data;

   bb3_req_if req_bus ();
   bb3_rsp_if rsp_bus ();

   box_blur_3x3_rgb_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_bus),
      .rsp_if   (rsp_bus),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_data (csr_data)
   );

   // Predictor state: frame registers, pixel window and the two frame counts.
   int unsigned        width_reg;
   int unsigned        height_reg;
   bb3_pkg::pixel_type pix_store [bb3_pkg::WIN_SIZE];
   int unsigned        pix_taken;
   int unsigned        pix_given;

   blur_res_type blur_queue [$];
   int           err_count;
   bit           calm_mode;
   int           stall_left;
   int           pixel_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] round_mean(int unsigned sum, int unsigned cnt);
      return 8'((2 * sum + cnt) / (2 * cnt));
   endfunction

   task automatic predict_blur(input logic kind, input bb3_pkg::pixel_type px,
                               output bit has, output blur_res_type res);
      int unsigned        w, h, total, row, col, cnt, sr, sg, sb, q;
      bb3_pkg::pixel_type nb;
      w = clamp_dim(width_reg, bb3_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, bb3_pkg::MAX_HEIGHT);
      total = w * h;
      has = 1'b0;
      res = '0;
      if (kind == KIND_PIXEL && pix_taken < total) begin
         pix_store[pix_taken % bb3_pkg::WIN_SIZE] = px;
         pix_taken++;
      end else if (pix_taken < total) begin
         return;
      end
      if (pix_given >= total) return;
      if (!(pix_taken == total || pix_taken >= pix_given + w + 2)) return;
      row = pix_given / w;
      col = pix_given % w;
      cnt = 0; sr = 0; sg = 0; sb = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            if (dr < 0 && row == 0) continue;
            if (dr > 0 && row + 1 >= h) continue;
            if (dc < 0 && col == 0) continue;
            if (dc > 0 && col + 1 >= w) continue;
            q = (row + dr) * w + (col + dc);
            nb = pix_store[q % bb3_pkg::WIN_SIZE];
            sr += nb.red;
            sg += nb.green;
            sb += nb.blue;
            cnt++;
         end
      end
      res.red   = round_mean(sr, cnt);
      res.green = round_mean(sg, cnt);
      res.blue  = round_mean(sb, cnt);
      has = 1'b1;
      pix_given++;
      if (pix_given == total) begin
         res.frame_end = 1'b1;
         pix_taken = 0;
         pix_given = 0;
      end
   endtask

   // Waits until every expected result is back and the block has gone quiet.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (blur_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [bb3_pkg::CSR_W-1:0] data);
      wait_idle();
      csr_we   <= 1'b1;
      csr_idx  <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = data & 13'h7FF;
      else height_reg = data & 13'h1FFF;
      pix_taken = 0;
      pix_given = 0;
   endtask

   task automatic send_request(input logic kind, input bb3_pkg::pixel_type px,
                               input row_chk_type chk, input blur_res_type typed);
      int           gap;
      bit           has;
      blur_res_type res;
      gap = 0;
      if (!calm_mode) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = $urandom_range(1, 3);
            3:       gap = $urandom_range(8, 40);
            default: gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.kind     <= kind;
      req_bus.red_in   <= px.red;
      req_bus.green_in <= px.green;
      req_bus.blue_in  <= px.blue;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_blur(kind, px, has, res);
      if (kind == KIND_PIXEL) pixel_count++;
      if (chk == CHK_TYPED) begin
         blur_queue.push_back(typed);
      end else if (chk == CHK_PREDICT && has) begin
         blur_queue.push_back(res);
      end
   endtask

   function automatic bb3_pkg::pixel_type rand_pixel();
      bb3_pkg::pixel_type p;
      p = bb3_pkg::pixel_type'(24'($urandom));
      if ($urandom_range(0, 7) == 0) p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 7) == 0) p.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return p;
   endfunction

   // Sends a frame of random pixels, with stray drains mixed in when noisy, optionally cut short;
   // a frame that is not cut short then has the rest of its results flushed.
   task automatic run_frame(input int unsigned limit_px, input bit noisy);
      int unsigned w, h, total, n;
      w = clamp_dim(width_reg, bb3_pkg::MAX_WIDTH);
      h = clamp_dim(height_reg, bb3_pkg::MAX_HEIGHT);
      total = w * h;
      n = (limit_px < total) ? limit_px : total;
      for (int unsigned i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_request(KIND_DRAIN, bb3_pkg::pixel_type'(24'($urandom)), CHK_PREDICT, '0);
         send_request(KIND_PIXEL, rand_pixel(), CHK_PREDICT, '0);
      end
      if (n < total) return;
      while (pix_taken != 0 || pix_given != 0) begin
         if ($urandom_range(0, 4) == 0)
            send_request(KIND_PIXEL, rand_pixel(), CHK_PREDICT, '0);
         else
            send_request(KIND_DRAIN, bb3_pkg::pixel_type'(24'($urandom)), CHK_PREDICT, '0);
      end
   endtask

   dir_row_type dir_rows [] = '{
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_DRAIN, 24'h000000, CHK_NONE, 25'h0},
      '{ROW_CFG, bb3_pkg::REG_FRAME_WIDTH, 13'd1, KIND_DRAIN, 24'h0, CHK_NONE, 25'h0},
      '{ROW_CFG, bb3_pkg::REG_FRAME_HEIGHT, 13'd1, KIND_DRAIN, 24'h0, CHK_NONE, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h000000, CHK_TYPED, {24'h000000, 1'b1}},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hFFFFFF, CHK_TYPED, {24'hFFFFFF, 1'b1}},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h5AA501, CHK_TYPED, {24'h5AA501, 1'b1}},
      '{ROW_CFG, bb3_pkg::REG_FRAME_WIDTH, 13'd0, KIND_DRAIN, 24'h0, CHK_NONE, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hA55A80, CHK_TYPED, {24'hA55A80, 1'b1}},
      '{ROW_CFG, bb3_pkg::REG_FRAME_WIDTH, 13'd3, KIND_DRAIN, 24'h0, CHK_NONE, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hFF00FF, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h00FF00, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h010203, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_DRAIN, 24'h0, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h777777, CHK_PREDICT, 25'h0},
      '{ROW_CFG, bb3_pkg::REG_FRAME_HEIGHT, 13'd3, KIND_DRAIN, 24'h0, CHK_NONE, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hFFFFFF, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h000000, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_DRAIN, 24'h0, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hFFFFFF, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h000001, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hFE01FE, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h80FF7F, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h00FF00, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hFF00FF, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'h123456, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_DRAIN, 24'h0, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_PIXEL, 24'hFFFFFF, CHK_PREDICT, 25'h0},
      '{ROW_PIXEL, 1'b0, 13'd0, KIND_DRAIN, 24'h0, CHK_PREDICT, 25'h0}
   };

   // Result side: random stalls outside calm mode, mostly short with the odd long one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm_mode) begin
            case ($urandom_range(0, 9))
               0, 1, 2: stall_left = $urandom_range(1, 3);
               3:       stall_left = $urandom_range(10, 40);
               default: stall_left = 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      blur_res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (blur_queue.size() == 0) begin
            $display("%0t: unexpected result %h %h %h end %b", $time, rsp_bus.red_out,
                     rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.frame_end);
            err_count++;
         end else begin
            want = blur_queue.pop_front();
            if (rsp_bus.red_out !== want.red) begin
               $display("%0t: red expected %h actual %h", $time, want.red, rsp_bus.red_out);
               err_count++;
            end
            if (rsp_bus.green_out !== want.green) begin
               $display("%0t: green expected %h actual %h", $time, want.green,
                        rsp_bus.green_out);
               err_count++;
            end
            if (rsp_bus.blue_out !== want.blue) begin
               $display("%0t: blue expected %h actual %h", $time, want.blue,
                        rsp_bus.blue_out);
               err_count++;
            end
            if (rsp_bus.frame_end !== want.frame_end) begin
               $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                        rsp_bus.frame_end);
               err_count++;
            end
         end
      end
   end

   initial begin
      int unsigned w_pick, h_pick, frames;
      err_count   = 0;
      pixel_count = 0;
      calm_mode   = 1'b0;
      width_reg   = 1024;
      height_reg  = 768;
      pix_taken   = 0;
      pix_given   = 0;
      foreach (pix_store[i]) pix_store[i] = '0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_idx          = 1'b0;
      csr_data         = '0;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_PIXEL;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].op == ROW_CFG)
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         else
            send_request(dir_rows[i].kind, dir_rows[i].px, dir_rows[i].chk,
                         dir_rows[i].res);
      end

      // Extremes first: oversize and zero dimensions, a tall single column, a full frame.
      write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd2047);
      write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd0);
      run_frame(30, 1'b0);
      write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd1);
      write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd8191);
      run_frame(12, 1'b1);
      write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd4096);
      run_frame(8, 1'b1);
      write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd1024);
      write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd4097);
      run_frame(20, 1'b0);
      write_reg(bb3_pkg::REG_FRAME_WIDTH, 13'd16);
      write_reg(bb3_pkg::REG_FRAME_HEIGHT, 13'd3);
      calm_mode = 1'b1;
      run_frame(64, 1'b0);
      calm_mode = 1'b0;

      pixel_count = 0;
      while (pixel_count < 250) begin
         calm_mode = ($urandom_range(0, 4) == 0);
         w_pick = $urandom_range(1, 8);
         h_pick = $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0) w_pick = $urandom_range(0, 2047);
         if ($urandom_range(0, 1))
            write_reg(bb3_pkg::REG_FRAME_WIDTH, bb3_pkg::CSR_W'(w_pick));
         if ($urandom_range(0, 1))
            write_reg(bb3_pkg::REG_FRAME_HEIGHT, bb3_pkg::CSR_W'(h_pick));
         frames = $urandom_range(1, 2);
         for (int f = 0; f < frames; f++) begin
            if (clamp_dim(width_reg, bb3_pkg::MAX_WIDTH) *
                clamp_dim(height_reg, bb3_pkg::MAX_HEIGHT) > 64
                || $urandom_range(0, 7) == 0)
               run_frame($urandom_range(1, 40), 1'b1);
            else
               run_frame(64, 1'b1);
         end
      end
      calm_mode = 1'b0;

      wait_idle();
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== box_blur_3x3_rgb_top.f =====
src/bb3_pkg.sv
src/bb3_if.sv
src/bb3_ctrl.sv
src/bb3_div.sv
src/bb3_dp.sv
src/box_blur_3x3_rgb_top.sv
tb/sv/box_blur_3x3_rgb_top_tb.sv
